// File: rtl/core/dse_pkg.sv
`timescale 1ns / 1ps

package dse_pkg;

  // fixed field widths
  localparam int unsigned ID_W   = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned RANK_W = 4;

  localparam int unsigned MAX_NODES_DEF = 1024;

  localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 11'd1024;
  localparam logic [RANK_W-1:0] RANK_MAX       = 4'd15;

  // operation codes
  typedef enum logic [1:0] {
    MODE_FIND  = 2'd0,
    MODE_MERGE = 2'd1,
    MODE_COUNT = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // sequencer states
  typedef enum logic [9:0] {
    S_INIT = 10'b00_0000_0001,
    S_IDLE = 10'b00_0000_0010,
    S_RD   = 10'b00_0000_0100,
    S_WALK = 10'b00_0000_1000,
    S_RKA  = 10'b00_0001_0000,
    S_RKB  = 10'b00_0010_0000,
    S_LINK = 10'b00_0100_0000,
    S_CLR  = 10'b00_1000_0000,
    S_MARK = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_e;

  // table write enables
  typedef struct packed {
    logic par;
    logic rank;
  } tbl_we_t;

endpackage

// File: rtl/core/disjoint_set_engine_core.sv
`timescale 1ns / 1ps
// find: walks the parent links from the node to its root and returns the root
// merge: walks from both nodes to their roots, then reads both ranks and links when the roots differ
// count: clears the seen map, then walks each node in use to its root; a flagged word, an
// unused mode or a count with no node in use answers without a walk; one word at a time
// after reset a clearing pass over all MaxNodes entries rebuilds the tables; no word is taken
// meanwhile, node_count returns to 1024 and configuration writes are taken at any time
module disjoint_set_engine_core #(
  parameter int unsigned MaxNodes = dse_pkg::MAX_NODES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [dse_pkg::CNT_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                mode_i,
  input  logic [dse_pkg::ID_W-1:0]  first_node_i,
  input  logic [dse_pkg::ID_W-1:0]  second_node_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [dse_pkg::ID_W-1:0]  root_found_o,
  output logic [dse_pkg::CNT_W-1:0] set_count_o,
  output logic                      status_o
);
  import dse_pkg::*;

  localparam int unsigned IdxW   = $clog2(MaxNodes);
  localparam int unsigned CapInt = (MaxNodes > 2047) ? 2047 : MaxNodes;
  localparam logic [CNT_W-1:0] Cap     = CNT_W'(CapInt);
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(MaxNodes - 1);

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [CNT_W-1:0]  node_count_q;
  logic [IdxW-1:0]   clr_q, clr_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [IdxW-1:0]   id_q, id_d;
  logic [IdxW-1:0]   nb_q, nb_d;
  logic [IdxW-1:0]   ra_q, ra_d;
  logic [IdxW-1:0]   rb_q, rb_d;
  logic [IdxW-1:0]   root_q, root_d;
  logic [RANK_W-1:0] rank_a_q, rank_a_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic [CNT_W-1:0]  sets_q, sets_d;
  logic              walk_b_q, walk_b_d;
  logic              status_q, status_d;

  logic              out_valid_q;
  logic [ID_W-1:0]   out_root_q;
  logic [CNT_W-1:0]  out_sets_q;
  logic              out_status_q;

  logic [CNT_W-1:0]  lim;
  logic              accept;
  logic              out_free;
  logic [IdxW+ID_W-1:0]  a_ext, b_ext, root_ext;
  logic [IdxW+CNT_W-1:0] scan_ext;
  logic [IdxW-1:0]   a_idx, b_idx, scan_idx;
  logic [CNT_W-1:0]  scan_nxt;
  logic [ID_W-1:0]   root_out;

  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   rd_par;
  logic [RANK_W-1:0] rd_rank;
  tbl_we_t           tbl_we;
  logic [IdxW-1:0]   par_waddr, par_wdata, rank_waddr;
  logic [RANK_W-1:0] rank_wdata;

  logic              seen_mem [MaxNodes];
  logic              seen_rd_q;
  logic              seen_we, seen_wdata;
  logic [IdxW-1:0]   seen_waddr;

  // effective node count
  assign lim = (node_count_q > Cap) ? Cap : node_count_q;

  // index conversions between port widths and table width
  assign a_ext    = {{IdxW{1'b0}}, first_node_i};
  assign b_ext    = {{IdxW{1'b0}}, second_node_i};
  assign a_idx    = a_ext[IdxW-1:0];
  assign b_idx    = b_ext[IdxW-1:0];
  assign scan_nxt = scan_q + CNT_W'(1);
  assign scan_ext = {{IdxW{1'b0}}, scan_nxt};
  assign scan_idx = scan_ext[IdxW-1:0];
  assign root_ext = {{ID_W{1'b0}}, root_q};
  assign root_out = root_ext[ID_W-1:0];

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  dse_tables #(
    .MaxNodes(MaxNodes)
  ) u_tables (
    .clk_i       (clk_i),
    .rd_addr_i   (rd_addr),
    .rd_parent_o (rd_par),
    .rd_rank_o   (rd_rank),
    .we_i        (tbl_we),
    .par_waddr_i (par_waddr),
    .par_wdata_i (par_wdata),
    .rank_waddr_i(rank_waddr),
    .rank_wdata_i(rank_wdata)
  );

  // seen map, read at the current node every cycle
  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[seen_waddr] <= seen_wdata;
    end
    seen_rd_q <= seen_mem[cur_q];
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    clr_d      = clr_q;
    cur_d      = cur_q;
    id_d       = id_q;
    nb_d       = nb_q;
    ra_d       = ra_q;
    rb_d       = rb_q;
    root_d     = root_q;
    rank_a_d   = rank_a_q;
    scan_d     = scan_q;
    sets_d     = sets_q;
    walk_b_d   = walk_b_q;
    status_d   = status_q;
    rd_addr    = cur_q;
    tbl_we     = '0;
    par_waddr  = id_q;
    par_wdata  = cur_q;
    rank_waddr = rb_q;
    rank_wdata = '0;
    seen_we    = 1'b0;
    seen_waddr = cur_q;
    seen_wdata = 1'b0;

    unique case (state_q)
      // rebuild tables after reset
      S_INIT: begin
        tbl_we.par  = 1'b1;
        tbl_we.rank = 1'b1;
        par_waddr   = clr_q;
        par_wdata   = clr_q;
        rank_waddr  = clr_q;
        rank_wdata  = '0;
        seen_we     = 1'b1;
        seen_waddr  = clr_q;
        if (clr_q == LastIdx) begin
          clr_d   = '0;
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + IdxW'(1);
        end
      end

      // take a word and decode the operation
      S_IDLE: begin
        if (accept) begin
          mode_d   = mode_e'(mode_i);
          root_d   = '0;
          sets_d   = '0;
          scan_d   = '0;
          status_d = 1'b0;
          walk_b_d = 1'b0;
          id_d     = a_idx;
          cur_d    = a_idx;
          nb_d     = b_idx;
          unique case (mode_e'(mode_i))
            MODE_FIND: begin
              if ({1'b0, first_node_i} >= lim) begin
                status_d = 1'b1;
                state_d  = S_DONE;
              end else begin
                state_d = S_RD;
              end
            end
            MODE_MERGE: begin
              if (({1'b0, first_node_i} >= lim) || ({1'b0, second_node_i} >= lim)) begin
                status_d = 1'b1;
                state_d  = S_DONE;
              end else begin
                state_d = S_RD;
              end
            end
            MODE_COUNT: begin
              id_d  = '0;
              cur_d = '0;
              state_d = (lim == '0) ? S_DONE : S_CLR;
            end
            MODE_NONE: begin
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // start a root walk at cur
      S_RD: begin
        rd_addr = cur_q;
        state_d = S_WALK;
      end

      // one parent link per cycle
      S_WALK: begin
        if (rd_par == cur_q) begin
          tbl_we.par = 1'b1;
          par_waddr  = id_q;
          par_wdata  = cur_q;
          case (mode_q)
            MODE_FIND: begin
              root_d  = cur_q;
              state_d = S_DONE;
            end
            MODE_MERGE: begin
              if (!walk_b_q) begin
                ra_d     = cur_q;
                walk_b_d = 1'b1;
                id_d     = nb_q;
                cur_d    = nb_q;
                state_d  = S_RD;
              end else if (cur_q == ra_q) begin
                root_d  = ra_q;
                state_d = S_DONE;
              end else begin
                rb_d    = cur_q;
                state_d = S_RKA;
              end
            end
            default: begin
              state_d = S_MARK;
            end
          endcase
        end else begin
          cur_d   = rd_par;
          rd_addr = rd_par;
        end
      end

      // rank of the first root
      S_RKA: begin
        rd_addr = ra_q;
        state_d = S_RKB;
      end

      // rank of the second root
      S_RKB: begin
        rd_addr  = rb_q;
        rank_a_d = rd_rank;
        state_d  = S_LINK;
      end

      // link by rank
      S_LINK: begin
        tbl_we.par = 1'b1;
        if (rank_a_q > rd_rank) begin
          par_waddr = rb_q;
          par_wdata = ra_q;
          root_d    = ra_q;
        end else begin
          par_waddr = ra_q;
          par_wdata = rb_q;
          root_d    = rb_q;
          if ((rank_a_q == rd_rank) && (rd_rank != RANK_MAX)) begin
            tbl_we.rank = 1'b1;
            rank_waddr  = rb_q;
            rank_wdata  = rd_rank + RANK_W'(1);
          end
        end
        state_d = S_DONE;
      end

      // clear the seen map before a count
      S_CLR: begin
        seen_we    = 1'b1;
        seen_waddr = clr_q;
        if (clr_q == LastIdx) begin
          clr_d   = '0;
          state_d = S_RD;
        end else begin
          clr_d = clr_q + IdxW'(1);
        end
      end

      // tally a new root, move to the next node
      S_MARK: begin
        if (!seen_rd_q) begin
          seen_we    = 1'b1;
          seen_waddr = cur_q;
          seen_wdata = 1'b1;
          sets_d     = sets_q + CNT_W'(1);
        end
        scan_d = scan_nxt;
        if (scan_nxt < lim) begin
          id_d    = scan_idx;
          cur_d   = scan_idx;
          state_d = S_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      clr_q        <= '0;
      node_count_q <= NODE_COUNT_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_valid_i) begin
        node_count_q <= cfg_data_i;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    cur_q    <= cur_d;
    id_q     <= id_d;
    nb_q     <= nb_d;
    ra_q     <= ra_d;
    rb_q     <= rb_d;
    root_q   <= root_d;
    rank_a_q <= rank_a_d;
    scan_q   <= scan_d;
    sets_q   <= sets_d;
    walk_b_q <= walk_b_d;
    status_q <= status_d;
    if ((state_q == S_DONE) && out_free) begin
      out_root_q   <= root_out;
      out_sets_q   <= sets_q;
      out_status_q <= status_q;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign root_found_o = out_root_q;
  assign set_count_o  = out_sets_q;
  assign status_o     = out_status_q;

  // a flagged word carries no root and no count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> ((root_found_o == '0) && (set_count_o == '0)))
    else $error("flagged word carries data");

  // at most one new set per scanned node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK) |-> (sets_q <= scan_q))
    else $error("set count ahead of scan");

  // linking only happens between distinct roots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |-> (ra_q != rb_q))
    else $error("link of a root to itself");

  // sweep counter rests at zero outside the clearing passes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (clr_q == '0))
    else $error("sweep counter not parked");

endmodule

// File: rtl/core/dse_tables.sv
`timescale 1ns / 1ps

module dse_tables #(
  parameter int unsigned MaxNodes = dse_pkg::MAX_NODES_DEF,
  localparam int unsigned IdxW    = $clog2(MaxNodes)
) (
  input  logic                       clk_i,
  input  logic [IdxW-1:0]            rd_addr_i,
  output logic [IdxW-1:0]            rd_parent_o,
  output logic [dse_pkg::RANK_W-1:0] rd_rank_o,
  input  dse_pkg::tbl_we_t           we_i,
  input  logic [IdxW-1:0]            par_waddr_i,
  input  logic [IdxW-1:0]            par_wdata_i,
  input  logic [IdxW-1:0]            rank_waddr_i,
  input  logic [dse_pkg::RANK_W-1:0] rank_wdata_i
);
  import dse_pkg::*;

  logic [IdxW-1:0]   par_mem  [MaxNodes];
  logic [RANK_W-1:0] rank_mem [MaxNodes];

  // parent links, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i.par) begin
      par_mem[par_waddr_i] <= par_wdata_i;
    end
    rd_parent_o <= par_mem[rd_addr_i];
  end

  // ranks, same read address as the parent links
  always_ff @(posedge clk_i) begin
    if (we_i.rank) begin
      rank_mem[rank_waddr_i] <= rank_wdata_i;
    end
    rd_rank_o <= rank_mem[rd_addr_i];
  end

endmodule
